/* sv/oriented_nearest_point_search_macros.svh */
// Assertion macros used by the oriented nearest point search checker.
`ifndef ORIENTED_NEAREST_POINT_SEARCH_MACROS_SVH
`define ORIENTED_NEAREST_POINT_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ONPS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("onps check failed");

// Next-cycle implication, disabled while reset is high.
`define ONPS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("onps check failed");

// Next-cycle implication that also holds across reset.
`define ONPS_ASSERT_ALWAYS_NEXT(label, clk, cond, prop) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("onps check failed");

`endif

/* sv/onps_pkg.sv */
// Shared constants and types of the oriented nearest point search.
package onps_pkg;

   localparam int CoordWidth      = 24;
   localparam int HeadWidth       = 16;
   localparam int RadiusWidth     = 48;
   localparam int IndexWidth      = 10;
   localparam int DistWidth       = 50;
   localparam int DiffWidth       = CoordWidth + 1;
   localparam int DotWidth        = 42;
   localparam int CsrDataWidth    = 48;
   localparam int CsrIndexWidth   = 3;
   localparam int QueueAddrWidth  = 3;
   localparam int QueueDepth      = 1 << QueueAddrWidth;
   localparam int QueueLevelWidth = QueueAddrWidth + 1;
   localparam int CountWidth      = 2;

   // point count saturates here: a range needs three points to report
   localparam logic [CountWidth-1:0] CountFull = 2'd3;
   localparam logic signed [HeadWidth-1:0] HeadingOne = 16'sd16384;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_VEHICLE_X      = 3'd0,
      CSR_VEHICLE_Y      = 3'd1,
      CSR_HEADING_COS    = 3'd2,
      CSR_HEADING_SIN    = 3'd3,
      CSR_RADIUS_SQUARED = 3'd4,
      CSR_BASE_INDEX     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] vehicle_x;
      logic signed [CoordWidth-1:0] vehicle_y;
      logic signed [HeadWidth-1:0]  heading_cos;
      logic signed [HeadWidth-1:0]  heading_sin;
      logic [RadiusWidth-1:0]       radius_squared;
      logic [IndexWidth-1:0]        base_index;
   } csr_type;

   typedef struct packed {
      logic                  start;
      logic                  last;
      logic                  count_ok;
      logic                  held_neg;
      logic [IndexWidth-1:0] held_idx;
      logic                  cur_neg;
      logic [IndexWidth-1:0] cur_idx;
   } item_tag_type;

   typedef struct packed {
      item_tag_type                tag;
      logic [DistWidth-1:0]        d_held;
      logic [DistWidth-1:0]        d_cur;
      logic                        dot_neg;
      logic signed [DiffWidth-1:0] dir_x;
      logic signed [DiffWidth-1:0] dir_y;
   } queue_entry_type;

   typedef struct packed {
      logic                       empty;
      logic [QueueLevelWidth-1:0] level;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_DIR_MUL,
      BK_FINISH
   } back_state_type;

endpackage

/* sv/onps_front.sv */
// Front end: accepts points, numbers them and computes distances and direction signs.
module onps_front import onps_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  csr_type                      csr,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [CoordWidth-1:0] req_point_x,
   input  logic signed [CoordWidth-1:0] req_point_y,
   input  logic                         req_speed_negative,
   input  logic                         req_last_point,
   input  queue_status_type             q_status,
   output logic                         push_valid,
   output queue_entry_type              push_entry
);

   logic                         accept;
   logic                         start;
   logic [IndexWidth-1:0]        cur_idx;
   logic [CountWidth-1:0]        count_next;
   logic [QueueLevelWidth-1:0]   in_flight;

   logic [CountWidth-1:0]        count_ff, count_in;
   logic [IndexWidth-1:0]        next_idx_ff, next_idx_in;
   logic signed [CoordWidth-1:0] held_x_ff, held_x_in;
   logic signed [CoordWidth-1:0] held_y_ff, held_y_in;
   logic                         held_neg_ff, held_neg_in;
   logic [IndexWidth-1:0]        held_idx_ff, held_idx_in;

   logic                         s1_valid_ff, s1_valid_in;
   item_tag_type                 s1_tag_ff, s1_tag_in;
   logic signed [DiffWidth-1:0]  s1_dxh_ff, s1_dxh_in;
   logic signed [DiffWidth-1:0]  s1_dyh_ff, s1_dyh_in;
   logic signed [DiffWidth-1:0]  s1_dxc_ff, s1_dxc_in;
   logic signed [DiffWidth-1:0]  s1_dyc_ff, s1_dyc_in;
   logic signed [DiffWidth-1:0]  s1_dir_x_ff, s1_dir_x_in;
   logic signed [DiffWidth-1:0]  s1_dir_y_ff, s1_dir_y_in;

   logic                         s2_valid_ff, s2_valid_in;
   item_tag_type                 s2_tag_ff, s2_tag_in;
   logic [DistWidth-1:0]         s2_sq_xh_ff, s2_sq_xh_in;
   logic [DistWidth-1:0]         s2_sq_yh_ff, s2_sq_yh_in;
   logic [DistWidth-1:0]         s2_sq_xc_ff, s2_sq_xc_in;
   logic [DistWidth-1:0]         s2_sq_yc_ff, s2_sq_yc_in;
   logic signed [DotWidth-1:0]   s2_dot_c_ff, s2_dot_c_in;
   logic signed [DotWidth-1:0]   s2_dot_s_ff, s2_dot_s_in;
   logic signed [DiffWidth-1:0]  s2_dir_x_ff, s2_dir_x_in;
   logic signed [DiffWidth-1:0]  s2_dir_y_ff, s2_dir_y_in;
   logic signed [DotWidth-1:0]   dot_sum;

   function automatic logic signed [DiffWidth-1:0] diff(
      input logic signed [CoordWidth-1:0] a,
      input logic signed [CoordWidth-1:0] b
   );
      diff = {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
   endfunction

   // credit check: queued plus in-flight items never exceed the queue depth
   assign in_flight = QueueLevelWidth'(s1_valid_ff) + QueueLevelWidth'(s2_valid_ff);
   assign req_ready = (q_status.level + in_flight) < QueueLevelWidth'(QueueDepth);

   always_comb begin
      accept     = req_valid && req_ready;
      start      = (count_ff == '0);
      cur_idx    = start ? csr.base_index : next_idx_ff;
      if (start) begin
         count_next = CountWidth'(1);
      end else if (count_ff == CountFull) begin
         count_next = CountFull;
      end else begin
         count_next = count_ff + 1'b1;
      end

      count_in    = count_ff;
      next_idx_in = next_idx_ff;
      held_x_in   = held_x_ff;
      held_y_in   = held_y_ff;
      held_neg_in = held_neg_ff;
      held_idx_in = held_idx_ff;
      if (accept) begin
         count_in    = req_last_point ? '0 : count_next;
         next_idx_in = cur_idx + 1'b1;
         if (!req_last_point) begin
            held_x_in   = req_point_x;
            held_y_in   = req_point_y;
            held_neg_in = req_speed_negative;
            held_idx_in = cur_idx;
         end
      end

      // stage 1: differences against the vehicle and the held point
      s1_valid_in        = accept;
      s1_tag_in.start    = start;
      s1_tag_in.last     = req_last_point;
      s1_tag_in.count_ok = (count_next == CountFull);
      s1_tag_in.held_neg = held_neg_ff;
      s1_tag_in.held_idx = held_idx_ff;
      s1_tag_in.cur_neg  = req_speed_negative;
      s1_tag_in.cur_idx  = cur_idx;
      s1_dxh_in          = diff(csr.vehicle_x, held_x_ff);
      s1_dyh_in          = diff(csr.vehicle_y, held_y_ff);
      s1_dxc_in          = diff(csr.vehicle_x, req_point_x);
      s1_dyc_in          = diff(csr.vehicle_y, req_point_y);
      s1_dir_x_in        = diff(req_point_x, held_x_ff);
      s1_dir_y_in        = diff(req_point_y, held_y_ff);

      // stage 2: squares and heading products
      s2_valid_in = s1_valid_ff;
      s2_tag_in   = s1_tag_ff;
      s2_sq_xh_in = DistWidth'(DistWidth'(s1_dxh_ff) * DistWidth'(s1_dxh_ff));
      s2_sq_yh_in = DistWidth'(DistWidth'(s1_dyh_ff) * DistWidth'(s1_dyh_ff));
      s2_sq_xc_in = DistWidth'(DistWidth'(s1_dxc_ff) * DistWidth'(s1_dxc_ff));
      s2_sq_yc_in = DistWidth'(DistWidth'(s1_dyc_ff) * DistWidth'(s1_dyc_ff));
      s2_dot_c_in = DotWidth'(csr.heading_cos) * DotWidth'(s1_dir_x_ff);
      s2_dot_s_in = DotWidth'(csr.heading_sin) * DotWidth'(s1_dir_y_ff);
      s2_dir_x_in = s1_dir_x_ff;
      s2_dir_y_in = s1_dir_y_ff;

      // sums feed the queue write
      dot_sum            = s2_dot_c_ff + s2_dot_s_ff;
      push_valid         = s2_valid_ff;
      push_entry.tag     = s2_tag_ff;
      push_entry.d_held  = s2_sq_xh_ff + s2_sq_yh_ff;
      push_entry.d_cur   = s2_sq_xc_ff + s2_sq_yc_ff;
      push_entry.dot_neg = dot_sum[DotWidth-1];
      push_entry.dir_x   = s2_dir_x_ff;
      push_entry.dir_y   = s2_dir_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      next_idx_ff <= next_idx_in;
      held_x_ff   <= held_x_in;
      held_y_ff   <= held_y_in;
      held_neg_ff <= held_neg_in;
      held_idx_ff <= held_idx_in;
      s1_tag_ff   <= s1_tag_in;
      s1_dxh_ff   <= s1_dxh_in;
      s1_dyh_ff   <= s1_dyh_in;
      s1_dxc_ff   <= s1_dxc_in;
      s1_dyc_ff   <= s1_dyc_in;
      s1_dir_x_ff <= s1_dir_x_in;
      s1_dir_y_ff <= s1_dir_y_in;
      s2_tag_ff   <= s2_tag_in;
      s2_sq_xh_ff <= s2_sq_xh_in;
      s2_sq_yh_ff <= s2_sq_yh_in;
      s2_sq_xc_ff <= s2_sq_xc_in;
      s2_sq_yc_ff <= s2_sq_yc_in;
      s2_dot_c_ff <= s2_dot_c_in;
      s2_dot_s_ff <= s2_dot_s_in;
      s2_dir_x_ff <= s2_dir_x_in;
      s2_dir_y_ff <= s2_dir_y_in;
   end

endmodule

/* sv/onps_queue.sv */
// Short queue of classified points between the front and back ends.
module onps_queue import onps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  head,
   output queue_status_type status
);

   queue_entry_type            entries_ff [QueueDepth];
   logic [QueueAddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueLevelWidth-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push_valid, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
      head         = entries_ff[rd_ptr_ff];
      status.empty = (level_ff == '0);
      status.level = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/onps_back.sv */
// Back end: running minimum with heading check and the result register.
module onps_back import onps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  csr_type               csr,
   input  queue_status_type      q_status,
   input  queue_entry_type       head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [IndexWidth-1:0] rsp_nearest_index
);

   back_state_type              state_ff, state_in;
   logic [DistWidth-1:0]        best_d_ff, best_d_in;
   logic [IndexWidth-1:0]       best_pos_ff, best_pos_in;
   logic                        best_valid_ff, best_valid_in;
   logic signed [DiffWidth-1:0] dir_x_ff, dir_x_in;
   logic signed [DiffWidth-1:0] dir_y_ff, dir_y_in;
   logic [DistWidth-1:0]        last_d_ff, last_d_in;
   logic                        last_neg_ff, last_neg_in;
   logic [IndexWidth-1:0]       last_idx_ff, last_idx_in;
   logic                        last_ok_ff, last_ok_in;
   logic signed [DotWidth-1:0]  prod_c_ff, prod_c_in;
   logic signed [DotWidth-1:0]  prod_s_ff, prod_s_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [IndexWidth-1:0]       rsp_idx_ff, rsp_idx_in;
   logic signed [DotWidth-1:0]  dot;
   logic                        take;
   logic                        found;

   always_comb begin
      state_in      = state_ff;
      best_d_in     = best_d_ff;
      best_pos_in   = best_pos_ff;
      best_valid_in = best_valid_ff;
      dir_x_in      = dir_x_ff;
      dir_y_in      = dir_y_ff;
      last_d_in     = last_d_ff;
      last_neg_in   = last_neg_ff;
      last_idx_in   = last_idx_ff;
      last_ok_in    = last_ok_ff;
      prod_c_in     = prod_c_ff;
      prod_s_in     = prod_s_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_idx_in    = rsp_idx_ff;
      pop           = 1'b0;
      dot           = prod_c_ff + prod_s_ff;
      take          = (last_d_ff < best_d_ff) && (dot[DotWidth-1] == last_neg_ff);
      found         = (take || best_valid_ff) && last_ok_ff;

      case (state_ff)
         BK_RUN: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (head.tag.start) begin
                  best_d_in     = DistWidth'(csr.radius_squared);
                  best_pos_in   = '0;
                  best_valid_in = 1'b0;
                  dir_x_in      = '0;
                  dir_y_in      = '0;
               end else if (head.d_held < best_d_ff) begin
                  // held point passes: its direction to this point is kept
                  dir_x_in = head.dir_x;
                  dir_y_in = head.dir_y;
                  if (head.dot_neg == head.tag.held_neg) begin
                     best_d_in     = head.d_held;
                     best_pos_in   = head.tag.held_idx;
                     best_valid_in = 1'b1;
                  end
               end
               if (head.tag.last) begin
                  last_d_in   = head.d_cur;
                  last_neg_in = head.tag.cur_neg;
                  last_idx_in = head.tag.cur_idx;
                  last_ok_in  = head.tag.count_ok;
                  state_in    = BK_DIR_MUL;
               end
            end
         end
         BK_DIR_MUL: begin
            // final point reuses the held direction
            prod_c_in = DotWidth'(csr.heading_cos) * DotWidth'(dir_x_ff);
            prod_s_in = DotWidth'(csr.heading_sin) * DotWidth'(dir_y_ff);
            state_in  = BK_FINISH;
         end
         BK_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (take) begin
                  best_d_in     = last_d_ff;
                  best_pos_in   = last_idx_ff;
                  best_valid_in = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_found_in = found;
               rsp_idx_in   = found ? (take ? last_idx_ff : best_pos_ff) : '0;
               state_in     = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_RUN;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      best_d_ff    <= best_d_in;
      best_pos_ff  <= best_pos_in;
      dir_x_ff     <= dir_x_in;
      dir_y_ff     <= dir_y_in;
      last_d_ff    <= last_d_in;
      last_neg_ff  <= last_neg_in;
      last_idx_ff  <= last_idx_in;
      last_ok_ff   <= last_ok_in;
      prod_c_ff    <= prod_c_in;
      prod_s_ff    <= prod_s_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_nearest_index = rsp_idx_ff;

endmodule

/* sv/oriented_nearest_point_search.sv */
// Top level of the oriented nearest point search: CSRs, front end, queue and back end.
//
// Streams path points and, on the point flagged last_point, returns one result
// transaction: whether a point lay strictly inside the search radius with a
// direction (to the following point) whose dot product with the heading has the
// sign of its speed, and the path index of the nearest such point. Points are
// taken one per cycle while the queue has room; each point's distance and heading
// sign are computed in a two-stage front pipeline (differences, then multiplies)
// and queued. The back end retires one queued point per cycle through the
// running-minimum compare, except the point that closes a range, which holds the
// back end through retire, heading multiply of the held direction and final
// compare; the final compare also waits until any previous result is taken. The
// result sits in an output register, so points keep flowing while a result waits.
// radius_squared and base_index are sampled by the first point of a range.
module oriented_nearest_point_search import onps_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [CsrDataWidth-1:0]      csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [CoordWidth-1:0] req_point_x,
   input  logic signed [CoordWidth-1:0] req_point_y,
   input  logic                         req_speed_negative,
   input  logic                         req_last_point,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic [IndexWidth-1:0]        rsp_nearest_index
);

   csr_type          csr_ff, csr_in;
   queue_status_type q_status;
   queue_entry_type  push_entry;
   queue_entry_type  head;
   logic             push_valid;
   logic             pop;

   // CSR write decode; unknown indexes are dropped
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_VEHICLE_X:      csr_in.vehicle_x      = csr_data[CoordWidth-1:0];
            CSR_VEHICLE_Y:      csr_in.vehicle_y      = csr_data[CoordWidth-1:0];
            CSR_HEADING_COS:    csr_in.heading_cos    = csr_data[HeadWidth-1:0];
            CSR_HEADING_SIN:    csr_in.heading_sin    = csr_data[HeadWidth-1:0];
            CSR_RADIUS_SQUARED: csr_in.radius_squared = csr_data[RadiusWidth-1:0];
            CSR_BASE_INDEX:     csr_in.base_index     = csr_data[IndexWidth-1:0];
            default:            csr_in                = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.vehicle_x      <= '0;
         csr_ff.vehicle_y      <= '0;
         csr_ff.heading_cos    <= HeadingOne;
         csr_ff.heading_sin    <= '0;
         csr_ff.radius_squared <= '0;
         csr_ff.base_index     <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front end: accept, index, distances and direction sign
   onps_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_speed_negative (req_speed_negative),
      .req_last_point     (req_last_point),
      .q_status           (q_status),
      .push_valid         (push_valid),
      .push_entry         (push_entry)
   );

   // decoupling queue; the front end reserves room before accepting
   onps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back end: running minimum and result transaction
   onps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr_ff),
      .q_status          (q_status),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_nearest_index (rsp_nearest_index)
   );

endmodule

/* sv/onps_checker.sv */
// Port-level checks of the oriented nearest point search, bound to the top level.
`include "oriented_nearest_point_search_macros.svh"

module onps_checker import onps_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_found,
   input logic [IndexWidth-1:0]        rsp_nearest_index
);

   logic [IndexWidth:0] rsp_payload;

   assign rsp_payload = {rsp_found, rsp_nearest_index};

   // a stalled result stays up
   `ONPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled result keeps its payload
   `ONPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))

   // no match reports index zero
   `ONPS_ASSERT_IMPLY(a_not_found_zero, clock, reset, rsp_valid && !rsp_found, rsp_nearest_index == '0)

   // reset drops any pending result
   `ONPS_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, !rsp_valid)

endmodule

bind oriented_nearest_point_search onps_checker u_onps_checker (.*);

/* tb/oriented_nearest_point_search_checker.sv */
// Checker for the oriented nearest point search: predicts each range's answer and compares.
module oriented_nearest_point_search_checker import onps_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [CsrDataWidth-1:0]      csr_data,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [CoordWidth-1:0] req_point_x,
   input  logic signed [CoordWidth-1:0] req_point_y,
   input  logic                         req_speed_negative,
   input  logic                         req_last_point,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_found,
   input  logic [IndexWidth-1:0]        rsp_nearest_index,
   output int                           mismatch_count,
   output int                           answers_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RangeCountCap = 1024;
   localparam int ShortRange    = 3;

   typedef struct packed {
      logic                  found;
      logic [IndexWidth-1:0] index;
   } answer_type;

   csr_type               settings;
   answer_type            pending_answers[$];
   longint                best_distance;
   logic [IndexWidth-1:0] best_index;
   logic                  best_ok;
   longint                held_x;
   longint                held_y;
   logic                  held_neg;
   logic [IndexWidth-1:0] held_index;
   logic [IndexWidth-1:0] running_index;
   longint                dir_x;
   longint                dir_y;
   int                    range_count;
   int                    errors = 0;

   // distance test first; direction only moves for points inside the current best
   function automatic void judge_candidate(longint x, longint y, logic neg,
                                           logic [IndexWidth-1:0] index, logic has_next,
                                           longint next_x, longint next_y);
      longint dx;
      longint dy;
      longint distance_sq;
      longint dot;
      dx = longint'($signed(settings.vehicle_x)) - x;
      dy = longint'($signed(settings.vehicle_y)) - y;
      distance_sq = dx * dx + dy * dy;
      if (distance_sq >= best_distance) return;
      if (has_next) begin
         dir_x = next_x - x;
         dir_y = next_y - y;
      end
      dot = longint'($signed(settings.heading_cos)) * dir_x
          + longint'($signed(settings.heading_sin)) * dir_y;
      if ((dot < 0) == neg) begin
         best_distance = distance_sq;
         best_index    = index;
         best_ok       = 1'b1;
      end
   endfunction

   function automatic void advance_search(longint px, longint py, logic neg, logic last);
      logic [IndexWidth-1:0] index;
      answer_type            answer;
      if (range_count == 0) begin
         best_distance = longint'(settings.radius_squared);
         best_ok       = 1'b0;
         best_index    = '0;
         dir_x         = 0;
         dir_y         = 0;
         running_index = settings.base_index;
      end
      index         = running_index;
      running_index = running_index + 1'b1;
      // the held point is judged now that its successor is known
      if (range_count > 0) judge_candidate(held_x, held_y, held_neg, held_index, 1'b1, px, py);
      if (range_count < RangeCountCap) range_count++;
      if (last) begin
         judge_candidate(px, py, neg, index, 1'b0, 0, 0);
         answer.found = best_ok && (range_count >= ShortRange);
         answer.index = answer.found ? best_index : '0;
         pending_answers.push_back(answer);
         range_count = 0;
      end else begin
         held_x     = px;
         held_y     = py;
         held_neg   = neg;
         held_index = index;
      end
   endfunction

   function automatic void check_answer(logic found, logic [IndexWidth-1:0] index);
      answer_type due;
      if (pending_answers.size() == 0) begin
         $display("%0t: unexpected result transaction, found %0d index %0d",
                  $time, found, index);
         errors++;
         return;
      end
      due = pending_answers.pop_front();
      if (found !== due.found) begin
         $display("%0t: found mismatch, expected %0d, actual %0d", $time, due.found, found);
         errors++;
      end
      if (index !== due.index) begin
         $display("%0t: nearest_index mismatch, expected %0d, actual %0d",
                  $time, due.index, index);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         settings.vehicle_x      = '0;
         settings.vehicle_y      = '0;
         settings.heading_cos    = HeadingOne;
         settings.heading_sin    = '0;
         settings.radius_squared = '0;
         settings.base_index     = '0;
         best_distance = 0;
         best_index    = '0;
         best_ok       = 1'b0;
         held_x        = 0;
         held_y        = 0;
         held_neg      = 1'b0;
         held_index    = '0;
         running_index = '0;
         dir_x         = 0;
         dir_y         = 0;
         range_count   = 0;
         pending_answers.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_VEHICLE_X:      settings.vehicle_x      = csr_data[CoordWidth-1:0];
               CSR_VEHICLE_Y:      settings.vehicle_y      = csr_data[CoordWidth-1:0];
               CSR_HEADING_COS:    settings.heading_cos    = csr_data[HeadWidth-1:0];
               CSR_HEADING_SIN:    settings.heading_sin    = csr_data[HeadWidth-1:0];
               CSR_RADIUS_SQUARED: settings.radius_squared = csr_data[RadiusWidth-1:0];
               CSR_BASE_INDEX:     settings.base_index     = csr_data[IndexWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            advance_search(longint'(req_point_x), longint'(req_point_y),
                           req_speed_negative, req_last_point);
         if (rsp_valid && rsp_ready) check_answer(rsp_found, rsp_nearest_index);
      end
      mismatch_count <= errors;
      answers_due    <= pending_answers.size();
   end

endmodule

/* tb/oriented_nearest_point_search_test.sv */
// Testbench top of the oriented nearest point search: stimulus, idling phases and verdict.
module oriented_nearest_point_search_test import onps_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // idle cycles after every answer is taken, letting the back end settle
   localparam int SettleCycles  = 8;
   // cycles without any transaction or register write before giving up
   localparam int QuietLimit    = 4000;
   // random points per phase; eight phases give about 400
   localparam int ItemsPerPhase = 50;

   logic                         clock              = 1'b0;
   logic                         reset              = 1'b1;
   logic                         csr_write_enable   = 1'b0;
   logic [CsrIndexWidth-1:0]     csr_index          = CSR_VEHICLE_X;
   logic [CsrDataWidth-1:0]      csr_data           = '0;
   logic                         req_valid          = 1'b0;
   logic                         req_ready;
   logic signed [CoordWidth-1:0] req_point_x        = '0;
   logic signed [CoordWidth-1:0] req_point_y        = '0;
   logic                         req_speed_negative = 1'b0;
   logic                         req_last_point     = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready          = 1'b0;
   logic                         rsp_found;
   logic [IndexWidth-1:0]        rsp_nearest_index;

   int mismatch_count;
   int answers_due;
   int send_idle_pct = 0;   // chance per cycle that the sender holds back
   int rsp_stall_pct = 0;   // chance per cycle that the receiver is not ready
   int quiet_cycles  = 0;

   always #1 clock = ~clock;

   oriented_nearest_point_search u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_speed_negative (req_speed_negative),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_nearest_index  (rsp_nearest_index)
   );

   oriented_nearest_point_search_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_speed_negative (req_speed_negative),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_nearest_index  (rsp_nearest_index),
      .mismatch_count     (mismatch_count),
      .answers_due        (answers_due)
   );

   // Receiver: ready is redrawn every cycle; a zero stall rate keeps it high.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: any transaction or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("oriented_nearest_point_search test failed");
         $finish;
      end
   end

   // One point transaction. Valid is only lowered on an idle cycle, never
   // between two back-to-back points, so it sees one assignment per step.
   task automatic send_point(input logic signed [CoordWidth-1:0] x,
                             input logic signed [CoordWidth-1:0] y,
                             input logic neg, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_point_x        <= x;
      req_point_y        <= y;
      req_speed_negative <= neg;
      req_last_point     <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Enable stays high across the six writes and drops once at the end.
   task automatic put_register(input csr_index_type which,
                               input logic [CsrDataWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_data         <= value;
      @(posedge clock);
   endtask

   task automatic program_registers(input csr_type s);
      put_register(CSR_VEHICLE_X,      CsrDataWidth'(s.vehicle_x));
      put_register(CSR_VEHICLE_Y,      CsrDataWidth'(s.vehicle_y));
      put_register(CSR_HEADING_COS,    CsrDataWidth'(s.heading_cos));
      put_register(CSR_HEADING_SIN,    CsrDataWidth'(s.heading_sin));
      put_register(CSR_RADIUS_SQUARED, s.radius_squared);
      put_register(CSR_BASE_INDEX,     CsrDataWidth'(s.base_index));
      csr_write_enable <= 1'b0;
   endtask

   // Sender holds off until every expected result has been taken, then lets
   // the back end settle. Registers are only touched after this.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin
      csr_type                      settings;
      int                           span;
      int                           length;
      int                           sent;
      int                           draw;
      longint                       rr;
      longint                       ox;
      longint                       oy;
      logic                         neg;
      logic signed [CoordWidth-1:0] px;
      logic signed [CoordWidth-1:0] py;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // Reset values: radius zero, so even a point on the vehicle is rejected.
      send_point(-24'sd8388608, 24'sd8388607, 1'b1, 1'b0);
      send_point(24'sd8388607, -24'sd8388608, 1'b0, 1'b0);
      send_point(24'sd0, 24'sd0, 1'b0, 1'b1);
      drain_results();

      // Vehicle at origin heading +x, widest radius, base near the index wrap.
      settings.vehicle_x      = '0;
      settings.vehicle_y      = '0;
      settings.heading_cos    = HeadingOne;
      settings.heading_sin    = '0;
      settings.radius_squared = '1;
      settings.base_index     = 10'd1022;
      program_registers(settings);
      // ranges of one and two points never report
      send_point(24'sd5, 24'sd0, 1'b0, 1'b1);
      send_point(24'sd1, 24'sd0, 1'b0, 1'b0);
      send_point(24'sd2, 24'sd0, 1'b0, 1'b1);
      // three points, first one moving against the heading
      send_point(24'sd3, 24'sd0, 1'b0, 1'b0);
      send_point(24'sd1, 24'sd0, 1'b0, 1'b0);
      send_point(24'sd2, 24'sd0, 1'b0, 1'b1);
      // repeated point: zero direction, zero dot agrees only with forward speed
      send_point(24'sd4, 24'sd4, 1'b0, 1'b0);
      send_point(24'sd4, 24'sd4, 1'b1, 1'b0);
      send_point(24'sd4, 24'sd4, 1'b1, 1'b1);
      // reversing: moving toward -x with negative speed agrees
      send_point(24'sd10, 24'sd0, 1'b1, 1'b0);
      send_point(24'sd5, 24'sd0, 1'b1, 1'b0);
      send_point(24'sd0, 24'sd0, 1'b1, 1'b1);
      drain_results();

      // Vehicle in a corner, heading cos at the most negative Q1.14 value, top base index.
      settings.vehicle_x      = 24'sd8388607;
      settings.vehicle_y      = -24'sd8388608;
      settings.heading_cos    = 16'h8000;
      settings.heading_sin    = HeadingOne;
      settings.radius_squared = '1;
      settings.base_index     = 10'd1023;
      program_registers(settings);
      send_point(24'sd8388607, -24'sd8388608, 1'b0, 1'b0);
      send_point(24'sd8388600, -24'sd8388600, 1'b1, 1'b0);
      // opposite corner: distance exceeds even the widest radius
      send_point(-24'sd8388608, 24'sd8388607, 1'b0, 1'b0);
      send_point(24'sd8388607, -24'sd8388607, 1'b0, 1'b1);
      drain_results();

      // --- random part ---
      // Two register settings per idling mode. Each range is a random walk
      // around the vehicle at a scale matched to the radius, with some noise
      // points anywhere in the plane.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 50; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 50; end
            default: begin send_idle_pct = 30; rsp_stall_pct <= 30; end
         endcase

         span = 1 << $urandom_range(2, 20);
         settings.vehicle_x = CoordWidth'(($urandom_range(3) == 0) ? $urandom()
                                          : $urandom_range(2000) - 1000);
         settings.vehicle_y = CoordWidth'(($urandom_range(3) == 0) ? $urandom()
                                          : $urandom_range(2000) - 1000);
         // headings mostly within Q1.14 one, sometimes any 16-bit value
         settings.heading_cos = HeadWidth'(($urandom_range(9) == 0) ? $urandom()
                                           : $urandom_range(32768) - 16384);
         settings.heading_sin = HeadWidth'(($urandom_range(9) == 0) ? $urandom()
                                           : $urandom_range(32768) - 16384);
         rr = longint'($urandom_range(2 * span));
         case ($urandom_range(19))
            0:       settings.radius_squared = '0;
            1, 2:    settings.radius_squared = '1;
            default: settings.radius_squared = RadiusWidth'(rr * rr);
         endcase
         settings.base_index = IndexWidth'($urandom());
         program_registers(settings);

         sent = 0;
         while (sent < ItemsPerPhase) begin
            draw = $urandom_range(99);
            if (draw < 8)       length = $urandom_range(1, 2);
            else if (draw < 92) length = $urandom_range(3, 10);
            else                length = $urandom_range(11, 40);
            ox  = longint'($urandom_range(2 * span)) - span;
            oy  = longint'($urandom_range(2 * span)) - span;
            neg = 1'($urandom_range(1));
            for (int k = 0; k < length; k++) begin
               if ($urandom_range(9) == 0) begin
                  px = CoordWidth'($urandom());
                  py = CoordWidth'($urandom());
               end else begin
                  // wraps at the coordinate width near the plane's edges
                  px = CoordWidth'(settings.vehicle_x + ox);
                  py = CoordWidth'(settings.vehicle_y + oy);
               end
               // speed sign mostly steady along a range, occasionally flipped
               send_point(px, py, ($urandom_range(6) == 0) ? ~neg : neg, k == length - 1);
               sent++;
               // now and then the walk stands still, giving a zero direction
               if ($urandom_range(9) != 0) begin
                  ox += longint'($urandom_range(span)) - span / 2;
                  oy += longint'($urandom_range(span)) - span / 2;
               end
            end
         end
         drain_results();
      end

      if (mismatch_count == 0 && answers_due == 0)
         $display("oriented_nearest_point_search test passed");
      else
         $display("oriented_nearest_point_search test failed");
      $finish;
   end

endmodule
